// File: rtl/mlcd_pkg.sv
// ----------------------------------------------------------------------------
// mlcd_pkg
// Shared types, command codes and reset values for the LCD command decoder.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    // default geometry of the display ram
    localparam int PAGES_DEFAULT   = 8;
    localparam int COLUMNS_DEFAULT = 132;

    // item kinds on the input channel
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_SCAN = 2'd2;

    // operand wait codes
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_VOLUME  = 2'd1;
    localparam logic [1:0] PEND_BOOSTER = 2'd2;

    // command byte codes (base of each group)
    localparam logic [7:0] CMD_COL_LOW    = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] CMD_RATIO      = 8'h20;
    localparam logic [7:0] CMD_POWER      = 8'h28;
    localparam logic [7:0] CMD_START_LINE = 8'h40;
    localparam logic [7:0] CMD_SEG_DIR    = 8'hA0;
    localparam logic [7:0] CMD_BIAS       = 8'hA2;
    localparam logic [7:0] CMD_ALL_ON     = 8'hA4;
    localparam logic [7:0] CMD_INVERSE    = 8'hA6;
    localparam logic [7:0] CMD_DISPLAY    = 8'hAE;
    localparam logic [7:0] CMD_PAGE       = 8'hB0;
    localparam logic [7:0] CMD_COM_DIR    = 8'hC0;
    localparam logic [7:0] CMD_VOLUME     = 8'h81;
    localparam logic [7:0] CMD_BOOSTER    = 8'hF8;
    localparam logic [7:0] CMD_RESET      = 8'hE2;

    // bit positions in the mode flags
    localparam int MODE_ON      = 0;
    localparam int MODE_SEG_REV = 1;
    localparam int MODE_COM_REV = 2;
    localparam int MODE_BIAS    = 3;
    localparam int MODE_INVERSE = 4;
    localparam int MODE_ALL_ON  = 5;

    localparam logic [5:0] VOLUME_RESET = 6'd32;

    // register file seen with every result
    typedef struct packed {
        logic [2:0] page;
        logic [7:0] column;
        logic [5:0] mode;
        logic [5:0] start_line;
        logic [2:0] power;
        logic [2:0] ratio;
        logic [5:0] volume;
        logic [1:0] booster;
        logic [1:0] pending;
    } t_regs;

    localparam t_regs REGS_RESET = '{
        page:       3'd0,
        column:     8'd0,
        mode:       6'd0,
        start_line: 6'd0,
        power:      3'd0,
        ratio:      3'd0,
        volume:     VOLUME_RESET,
        booster:    2'd0,
        pending:    PEND_NONE
    };

    // ram operation carried by a queued transaction
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // queued transaction without the ram address
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        t_regs      regs;
    } t_entry;

endpackage

// File: rtl/mlcd_ram.sv
// ----------------------------------------------------------------------------
// mlcd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1056,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mlcd_front.sv
// ----------------------------------------------------------------------------
// mlcd_front
// Accepts bus transactions, decodes command bytes into the register file and
// classifies each transaction into a ram write, a ram read or nothing.
// ----------------------------------------------------------------------------
module mlcd_front #(
    parameter int PAGES   = mlcd_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = mlcd_pkg::COLUMNS_DEFAULT,
    parameter int AW      = $clog2(PAGES * COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_bus_byte,
    input  logic [2:0]        i_scan_page,
    input  logic [7:0]        i_scan_column,
    output mlcd_pkg::t_entry  o_entry,
    output logic [AW-1:0]     o_addr,
    output mlcd_pkg::t_regs   o_regs
);

    localparam logic [7:0] COL_LIMIT  = 8'(COLUMNS);
    localparam logic [3:0] PAGE_LIMIT = 4'(PAGES);

    mlcd_pkg::t_regs r_regs;
    mlcd_pkg::t_regs n_regs;
    mlcd_pkg::t_op   w_op;
    logic [2:0]      w_page_sel;
    logic [7:0]      w_col_sel;
    logic [7:0]      w_c;

    assign w_c = i_bus_byte;

    // command decode and pointer update
    always_comb begin
        n_regs     = r_regs;
        w_op       = mlcd_pkg::OP_NONE;
        w_page_sel = r_regs.page;
        w_col_sel  = r_regs.column;
        if (i_kind == mlcd_pkg::KIND_CMD) begin
            if (r_regs.pending == mlcd_pkg::PEND_VOLUME) begin
                n_regs.volume  = w_c[5:0];
                n_regs.pending = mlcd_pkg::PEND_NONE;
            end else if (r_regs.pending == mlcd_pkg::PEND_BOOSTER) begin
                n_regs.booster = w_c[1:0];
                n_regs.pending = mlcd_pkg::PEND_NONE;
            end else if (w_c[7:4] == mlcd_pkg::CMD_COL_LOW[7:4]) begin
                n_regs.column[3:0] = w_c[3:0];
            end else if (w_c[7:4] == mlcd_pkg::CMD_COL_HIGH[7:4]) begin
                n_regs.column[7:4] = w_c[3:0];
            end else if (w_c[7:3] == mlcd_pkg::CMD_RATIO[7:3]) begin
                n_regs.ratio = w_c[2:0];
            end else if (w_c[7:3] == mlcd_pkg::CMD_POWER[7:3]) begin
                n_regs.power = w_c[2:0];
            end else if (w_c[7:6] == mlcd_pkg::CMD_START_LINE[7:6]) begin
                n_regs.start_line = w_c[5:0];
            end else if (w_c[7:1] == mlcd_pkg::CMD_SEG_DIR[7:1]) begin
                n_regs.mode[mlcd_pkg::MODE_SEG_REV] = w_c[0];
            end else if (w_c[7:1] == mlcd_pkg::CMD_BIAS[7:1]) begin
                n_regs.mode[mlcd_pkg::MODE_BIAS] = w_c[0];
            end else if (w_c[7:1] == mlcd_pkg::CMD_ALL_ON[7:1]) begin
                n_regs.mode[mlcd_pkg::MODE_ALL_ON] = w_c[0];
            end else if (w_c[7:1] == mlcd_pkg::CMD_INVERSE[7:1]) begin
                n_regs.mode[mlcd_pkg::MODE_INVERSE] = w_c[0];
            end else if (w_c[7:1] == mlcd_pkg::CMD_DISPLAY[7:1]) begin
                n_regs.mode[mlcd_pkg::MODE_ON] = w_c[0];
            end else if (w_c[7:3] == mlcd_pkg::CMD_PAGE[7:3]) begin
                n_regs.page = w_c[2:0];
            end else if (w_c[7:4] == mlcd_pkg::CMD_COM_DIR[7:4]) begin
                n_regs.mode[mlcd_pkg::MODE_COM_REV] = w_c[3];
            end else if (w_c == mlcd_pkg::CMD_VOLUME) begin
                n_regs.pending = mlcd_pkg::PEND_VOLUME;
            end else if (w_c == mlcd_pkg::CMD_BOOSTER) begin
                n_regs.pending = mlcd_pkg::PEND_BOOSTER;
            end else if (w_c == mlcd_pkg::CMD_RESET) begin
                n_regs = mlcd_pkg::REGS_RESET;
            end
        end else if (i_kind == mlcd_pkg::KIND_DATA) begin
            // writes past the last column are dropped, off-screen pages store nothing
            if (r_regs.column < COL_LIMIT) begin
                if ({1'b0, r_regs.page} < PAGE_LIMIT) begin
                    w_op = mlcd_pkg::OP_WRITE;
                end
                n_regs.column = r_regs.column + 8'd1;
            end
        end else if (i_kind == mlcd_pkg::KIND_SCAN) begin
            w_page_sel = i_scan_page;
            w_col_sel  = i_scan_column;
            if (({1'b0, i_scan_page} < PAGE_LIMIT) && (i_scan_column < COL_LIMIT)) begin
                w_op = mlcd_pkg::OP_READ;
            end
        end
    end

    // ram address: page times row length plus column
    assign o_addr = AW'(32'(w_page_sel) * 32'(COLUMNS) + 32'(w_col_sel));

    always_comb begin
        o_entry.op   = w_op;
        o_entry.data = i_bus_byte;
        o_entry.regs = n_regs;
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= mlcd_pkg::REGS_RESET;
        end else if (i_accept) begin
            r_regs <= n_regs;
        end
    end

    assign o_regs = r_regs;

endmodule

// File: rtl/mlcd_fifo.sv
// ----------------------------------------------------------------------------
// mlcd_fifo
// Two-entry queue between the decode front and the ram back end.
// ----------------------------------------------------------------------------
module mlcd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

// File: rtl/mlcd_back.sv
// ----------------------------------------------------------------------------
// mlcd_back
// Carries out queued ram writes and scan reads and holds the result register
// for the output channel.
// ----------------------------------------------------------------------------
module mlcd_back #(
    parameter int PAGES   = mlcd_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = mlcd_pkg::COLUMNS_DEFAULT,
    parameter int AW      = $clog2(PAGES * COLUMNS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mlcd_pkg::t_entry i_entry,
    input  logic [AW-1:0]    i_addr,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_scan_data,
    output mlcd_pkg::t_regs  o_regs
);

    logic            r_valid;
    logic            r_is_read;
    mlcd_pkg::t_regs r_regs;
    logic [7:0]      w_rdata;
    logic            w_we;
    logic            w_re;

    // take the next transaction when the result slot is free or leaving
    assign o_pop = !i_empty && (!r_valid || !i_stall);
    assign w_we  = o_pop && (i_entry.op == mlcd_pkg::OP_WRITE);
    assign w_re  = o_pop && (i_entry.op == mlcd_pkg::OP_READ);

    mlcd_ram #(
        .WIDTH (8),
        .DEPTH (PAGES * COLUMNS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_addr),
        .i_wdata (i_entry.data),
        .i_re    (w_re),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    // result slot control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result slot payload; read data stays in the ram register until next read
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_read <= (i_entry.op == mlcd_pkg::OP_READ);
            r_regs    <= i_entry.regs;
        end
    end

    assign o_valid     = r_valid;
    assign o_scan_data = r_is_read ? w_rdata : 8'd0;
    assign o_regs      = r_regs;

endmodule

// File: rtl/mono_lcd_controller_command_decoder.sv
// ----------------------------------------------------------------------------
// mono_lcd_controller_command_decoder
// Page-addressed monochrome LCD controller: command decode, register file
// and display RAM, one result per bus transaction.
// ----------------------------------------------------------------------------
// Each transaction (command byte, data byte or scan read) yields exactly one
// result that shows the register file after it, plus the RAM byte on a scan.
// The block takes one transaction per clock and keeps that pace while results
// are taken every cycle; a transaction passes through the queue and then the
// result register before its result turns valid. The front decodes a
// transaction in its accept cycle, a two-entry queue follows, and the back end
// performs the single RAM access per transaction with a registered read, on
// separate write and read ports. The display RAM is not cleared at reset:
// reading a byte never written returns an undefined value. A stalled output
// backs up into the queue, and the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module mono_lcd_controller_command_decoder #(
    parameter int PAGES   = mlcd_pkg::PAGES_DEFAULT,
    parameter int COLUMNS = mlcd_pkg::COLUMNS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_bus_byte,
    input  logic [2:0] i_scan_page,
    input  logic [7:0] i_scan_column,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_scan_data,
    output logic [2:0] o_page_address,
    output logic [7:0] o_column_address,
    output logic [5:0] o_mode_flags,
    output logic [5:0] o_start_line,
    output logic [2:0] o_power_control,
    output logic [2:0] o_resistor_ratio,
    output logic [5:0] o_contrast,
    output logic [1:0] o_booster_ratio,
    output logic [1:0] o_awaiting_operand
);

    localparam int AW = $clog2(PAGES * COLUMNS);
    localparam int EW = $bits(mlcd_pkg::t_entry);
    localparam int QW = AW + EW;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    mlcd_pkg::t_entry w_front_entry;
    logic [AW-1:0]    w_front_addr;
    mlcd_pkg::t_regs  w_front_regs;
    logic [QW-1:0]    w_q_rdata;
    mlcd_pkg::t_entry w_back_entry;
    logic [AW-1:0]    w_back_addr;
    mlcd_pkg::t_regs  w_out_regs;

    // input handshake
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    mlcd_front #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_kind        (i_kind),
        .i_bus_byte    (i_bus_byte),
        .i_scan_page   (i_scan_page),
        .i_scan_column (i_scan_column),
        .o_entry       (w_front_entry),
        .o_addr        (w_front_addr),
        .o_regs        (w_front_regs)
    );

    mlcd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata ({w_front_addr, w_front_entry}),
        .i_pop   (w_pop),
        .o_rdata (w_q_rdata),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_back_entry = w_q_rdata[EW-1:0];
    assign w_back_addr  = w_q_rdata[QW-1:EW];

    mlcd_back #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (w_back_entry),
        .i_addr      (w_back_addr),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_scan_data (o_scan_data),
        .o_regs      (w_out_regs)
    );

    // result fields
    assign o_page_address     = w_out_regs.page;
    assign o_column_address   = w_out_regs.column;
    assign o_mode_flags       = w_out_regs.mode;
    assign o_start_line       = w_out_regs.start_line;
    assign o_power_control    = w_out_regs.power;
    assign o_resistor_ratio   = w_out_regs.ratio;
    assign o_contrast         = w_out_regs.volume;
    assign o_booster_ratio    = w_out_regs.booster;
    assign o_awaiting_operand = w_out_regs.pending;

`ifndef ASSERT_OFF
    // register reset command restores contrast and clears the operand wait
    a_reg_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == mlcd_pkg::KIND_CMD && i_bus_byte == mlcd_pkg::CMD_RESET
            && w_front_regs.pending == mlcd_pkg::PEND_NONE)
        |=> (w_front_regs.volume == mlcd_pkg::VOLUME_RESET
            && w_front_regs.pending == mlcd_pkg::PEND_NONE))
        else $error("register reset did not restore defaults");

    // data write past the last column leaves the column pointer alone
    a_col_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == mlcd_pkg::KIND_DATA
            && w_front_regs.column >= 8'(COLUMNS))
        |=> $stable(w_front_regs.column))
        else $error("column pointer moved past the end");

    // a non-read result never shows ram data
    a_scan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_back_entry.op != mlcd_pkg::OP_READ)
        |=> (o_scan_data == 8'd0))
        else $error("scan data on a non-read result");

    // the operand wait never holds an unused code
    a_pending_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_front_regs.pending != 2'd3)
        else $error("illegal operand wait code");
`endif

endmodule

// File: test/mono_lcd_controller_command_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mono_lcd_controller_command_decoder_tb
// Self-checking bench for the LCD command decoder. A local model of the
// register file and display RAM predicts the result of every accepted
// transaction. A checker compares each output transaction field by field.
// Directed tests cover every command group, operand bytes, register reset
// and the column end. Random command, data and scan traffic follows, with
// random idle and stall on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module mono_lcd_controller_command_decoder_tb;

    localparam int PAGES   = mlcd_pkg::PAGES_DEFAULT;
    localparam int COLUMNS = mlcd_pkg::COLUMNS_DEFAULT;

    localparam int RESET_CYCLES     = 6;
    localparam int OUT_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int END_SLACK_CYCLES = 8;
    localparam int PRINT_LIMIT      = 50;

    // expected view of one output transaction
    typedef struct packed {
        logic [7:0]      scan_data;
        mlcd_pkg::t_regs regs;
    } t_lcd_view;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_kind;
    logic [7:0] i_bus_byte;
    logic [2:0] i_scan_page;
    logic [7:0] i_scan_column;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_scan_data;
    logic [2:0] o_page_address;
    logic [7:0] o_column_address;
    logic [5:0] o_mode_flags;
    logic [5:0] o_start_line;
    logic [2:0] o_power_control;
    logic [2:0] o_resistor_ratio;
    logic [5:0] o_contrast;
    logic [1:0] o_booster_ratio;
    logic [1:0] o_awaiting_operand;

    // local copy of the controller state
    mlcd_pkg::t_regs lcd_regs = mlcd_pkg::REGS_RESET;
    logic [7:0]   lcd_ram [PAGES*COLUMNS];
    bit           ram_written [PAGES*COLUMNS];
    int unsigned  written_addrs [$];
    t_lcd_view    expected_views [$];

    int unsigned  items_sent;
    int unsigned  results_seen;
    int unsigned  mismatches;
    int unsigned  idle_cycles;
    bit           quiet_traffic;
    bit           quiet_receiver;
    bit           hold_request;

    mono_lcd_controller_command_decoder #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_bus_byte         (i_bus_byte),
        .i_scan_page        (i_scan_page),
        .i_scan_column      (i_scan_column),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_scan_data        (o_scan_data),
        .o_page_address     (o_page_address),
        .o_column_address   (o_column_address),
        .o_mode_flags       (o_mode_flags),
        .o_start_line       (o_start_line),
        .o_power_control    (o_power_control),
        .o_resistor_ratio   (o_resistor_ratio),
        .o_contrast         (o_contrast),
        .o_booster_ratio    (o_booster_ratio),
        .o_awaiting_operand (o_awaiting_operand)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // idle length: mostly short, a few long
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // update the local state for one accepted transaction and queue its view
    task automatic apply_bus_access(input logic [1:0] kind, input logic [7:0] bus_byte,
                                    input logic [2:0] scan_page,
                                    input logic [7:0] scan_column);
        t_lcd_view   view;
        int unsigned addr;
        view.scan_data = 8'h00;
        if (kind == mlcd_pkg::KIND_CMD) begin
            // an awaited operand takes the byte whatever its value
            if (lcd_regs.pending == mlcd_pkg::PEND_VOLUME) begin
                lcd_regs.volume  = bus_byte[5:0];
                lcd_regs.pending = mlcd_pkg::PEND_NONE;
            end else if (lcd_regs.pending == mlcd_pkg::PEND_BOOSTER) begin
                lcd_regs.booster = bus_byte[1:0];
                lcd_regs.pending = mlcd_pkg::PEND_NONE;
            end else if (bus_byte[7:4] == mlcd_pkg::CMD_COL_LOW[7:4]) begin
                lcd_regs.column[3:0] = bus_byte[3:0];
            end else if (bus_byte[7:4] == mlcd_pkg::CMD_COL_HIGH[7:4]) begin
                lcd_regs.column[7:4] = bus_byte[3:0];
            end else if (bus_byte[7:3] == mlcd_pkg::CMD_RATIO[7:3]) begin
                lcd_regs.ratio = bus_byte[2:0];
            end else if (bus_byte[7:3] == mlcd_pkg::CMD_POWER[7:3]) begin
                lcd_regs.power = bus_byte[2:0];
            end else if (bus_byte[7:6] == mlcd_pkg::CMD_START_LINE[7:6]) begin
                lcd_regs.start_line = bus_byte[5:0];
            end else if (bus_byte[7:1] == mlcd_pkg::CMD_SEG_DIR[7:1]) begin
                lcd_regs.mode[mlcd_pkg::MODE_SEG_REV] = bus_byte[0];
            end else if (bus_byte[7:1] == mlcd_pkg::CMD_BIAS[7:1]) begin
                lcd_regs.mode[mlcd_pkg::MODE_BIAS] = bus_byte[0];
            end else if (bus_byte[7:1] == mlcd_pkg::CMD_ALL_ON[7:1]) begin
                lcd_regs.mode[mlcd_pkg::MODE_ALL_ON] = bus_byte[0];
            end else if (bus_byte[7:1] == mlcd_pkg::CMD_INVERSE[7:1]) begin
                lcd_regs.mode[mlcd_pkg::MODE_INVERSE] = bus_byte[0];
            end else if (bus_byte[7:1] == mlcd_pkg::CMD_DISPLAY[7:1]) begin
                lcd_regs.mode[mlcd_pkg::MODE_ON] = bus_byte[0];
            end else if (bus_byte[7:3] == mlcd_pkg::CMD_PAGE[7:3]) begin
                lcd_regs.page = bus_byte[2:0];
            end else if (bus_byte[7:4] == mlcd_pkg::CMD_COM_DIR[7:4]) begin
                lcd_regs.mode[mlcd_pkg::MODE_COM_REV] = bus_byte[3];
            end else if (bus_byte == mlcd_pkg::CMD_VOLUME) begin
                lcd_regs.pending = mlcd_pkg::PEND_VOLUME;
            end else if (bus_byte == mlcd_pkg::CMD_BOOSTER) begin
                lcd_regs.pending = mlcd_pkg::PEND_BOOSTER;
            end else if (bus_byte == mlcd_pkg::CMD_RESET) begin
                lcd_regs = mlcd_pkg::REGS_RESET;
            end
        end else if (kind == mlcd_pkg::KIND_DATA) begin
            // writes past the last column are dropped, pointer stops there
            if (int'(lcd_regs.column) < COLUMNS) begin
                if (int'(lcd_regs.page) < PAGES) begin
                    addr = int'(lcd_regs.page) * COLUMNS + int'(lcd_regs.column);
                    lcd_ram[addr] = bus_byte;
                    if (!ram_written[addr]) begin
                        ram_written[addr] = 1'b1;
                        written_addrs.push_back(addr);
                    end
                end
                lcd_regs.column = lcd_regs.column + 8'd1;
            end
        end else if (kind == mlcd_pkg::KIND_SCAN) begin
            if (int'(scan_page) < PAGES && int'(scan_column) < COLUMNS)
                view.scan_data = lcd_ram[int'(scan_page) * COLUMNS + int'(scan_column)];
        end
        view.regs = lcd_regs;
        expected_views.push_back(view);
    endtask

    // offer one transaction, wait for acceptance, then maybe idle
    task automatic send_item(input logic [1:0] kind, input logic [7:0] bus_byte,
                             input logic [2:0] scan_page, input logic [7:0] scan_column);
        int unsigned gap;
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_bus_byte    <= bus_byte;
        i_scan_page   <= scan_page;
        i_scan_column <= scan_column;
        do
            @(posedge i_clk);
        while (o_in_stall);
        items_sent++;
        apply_bus_access(kind, bus_byte, scan_page, scan_column);
        gap = (quiet_traffic || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_command(input logic [7:0] code);
        send_item(mlcd_pkg::KIND_CMD, code, 3'($urandom), 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] value);
        send_item(mlcd_pkg::KIND_DATA, value, 3'($urandom), 8'($urandom));
    endtask

    // scan a written byte or an address past the last column
    task automatic send_scan();
        int unsigned addr;
        logic [2:0]  page;
        logic [7:0]  column;
        if (written_addrs.size() == 0 || $urandom_range(0, 5) == 0) begin
            page   = 3'($urandom);
            column = 8'($urandom_range(COLUMNS, 255));
        end else begin
            addr   = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            page   = 3'(addr / COLUMNS);
            column = 8'(addr % COLUMNS);
        end
        send_item(mlcd_pkg::KIND_SCAN, 8'($urandom), page, column);
    endtask

    // drop valid after the last transaction of a phase
    task automatic bus_idle();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        bus_idle();
        while (expected_views.size() != 0)
            @(posedge i_clk);
    endtask

    // random traffic: mostly well-formed sequences, some noise
    task automatic run_random_traffic(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        int unsigned burst;
        logic [7:0]  column;
        logic [7:0]  page_code;
        logic [1:0]  kind;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // window write: page, column, then a data burst
                page_code = ($urandom_range(0, 7) == 0)
                    ? mlcd_pkg::CMD_PAGE | 8'($urandom_range(8, 15))
                    : mlcd_pkg::CMD_PAGE | 8'($urandom_range(0, 7));
                case ($urandom_range(0, 15))
                    0:       column = 8'($urandom_range(COLUMNS, 255));
                    1, 2:    column = 8'($urandom_range(COLUMNS - 8, COLUMNS - 1));
                    default: column = 8'($urandom_range(0, COLUMNS - 1));
                endcase
                send_command(page_code);
                if ($urandom_range(0, 1) == 0) begin
                    send_command(mlcd_pkg::CMD_COL_HIGH | {4'h0, column[7:4]});
                    send_command(mlcd_pkg::CMD_COL_LOW | {4'h0, column[3:0]});
                end else begin
                    send_command(mlcd_pkg::CMD_COL_LOW | {4'h0, column[3:0]});
                    send_command(mlcd_pkg::CMD_COL_HIGH | {4'h0, column[7:4]});
                end
                burst = $urandom_range(1, 12);
                repeat (burst) send_data(8'($urandom));
            end else if (pick < 55) begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_scan();
            end else if (pick < 75) begin
                // one well-formed single-byte command
                case ($urandom_range(0, 11))
                    0:  send_command(mlcd_pkg::CMD_COL_LOW | 8'($urandom_range(0, 15)));
                    1:  send_command(mlcd_pkg::CMD_COL_HIGH | 8'($urandom_range(0, 15)));
                    2:  send_command(mlcd_pkg::CMD_RATIO | 8'($urandom_range(0, 7)));
                    3:  send_command(mlcd_pkg::CMD_POWER | 8'($urandom_range(0, 7)));
                    4:  send_command(mlcd_pkg::CMD_START_LINE | 8'($urandom_range(0, 63)));
                    5:  send_command(mlcd_pkg::CMD_SEG_DIR | 8'($urandom_range(0, 1)));
                    6:  send_command(mlcd_pkg::CMD_BIAS | 8'($urandom_range(0, 1)));
                    7:  send_command(mlcd_pkg::CMD_ALL_ON | 8'($urandom_range(0, 1)));
                    8:  send_command(mlcd_pkg::CMD_INVERSE | 8'($urandom_range(0, 1)));
                    9:  send_command(mlcd_pkg::CMD_DISPLAY | 8'($urandom_range(0, 1)));
                    10: send_command(mlcd_pkg::CMD_PAGE | 8'($urandom_range(0, 7)));
                    default: send_command(mlcd_pkg::CMD_COM_DIR | 8'($urandom_range(0, 15)));
                endcase
            end else if (pick < 85) begin
                // two-byte register, sometimes with data or scan in between
                send_command(($urandom_range(0, 1) == 0) ? mlcd_pkg::CMD_VOLUME
                                                         : mlcd_pkg::CMD_BOOSTER);
                case ($urandom_range(0, 7))
                    0:       send_data(8'($urandom));
                    1:       send_scan();
                    default: ;
                endcase
                send_command(8'($urandom));
            end else if (pick < 90) begin
                send_command(mlcd_pkg::CMD_RESET);
            end else begin
                // noise of any kind, unused kind included
                kind = 2'($urandom);
                if (kind == mlcd_pkg::KIND_SCAN)
                    send_scan();
                else
                    send_item(kind, 8'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // compare every output transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_lcd_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected result", o_column_address, 0);
            end else begin
                want = expected_views.pop_front();
                if (o_scan_data !== want.scan_data)
                    report_mismatch("scan_data", o_scan_data, want.scan_data);
                if (o_page_address !== want.regs.page)
                    report_mismatch("page_address", o_page_address, want.regs.page);
                if (o_column_address !== want.regs.column)
                    report_mismatch("column_address", o_column_address, want.regs.column);
                if (o_mode_flags !== want.regs.mode)
                    report_mismatch("mode_flags", o_mode_flags, want.regs.mode);
                if (o_start_line !== want.regs.start_line)
                    report_mismatch("start_line", o_start_line, want.regs.start_line);
                if (o_power_control !== want.regs.power)
                    report_mismatch("power_control", o_power_control, want.regs.power);
                if (o_resistor_ratio !== want.regs.ratio)
                    report_mismatch("resistor_ratio", o_resistor_ratio, want.regs.ratio);
                if (o_contrast !== want.regs.volume)
                    report_mismatch("contrast", o_contrast, want.regs.volume);
                if (o_booster_ratio !== want.regs.booster)
                    report_mismatch("booster_ratio", o_booster_ratio, want.regs.booster);
                if (o_awaiting_operand !== want.regs.pending)
                    report_mismatch("awaiting_operand", o_awaiting_operand, want.regs.pending);
            end
            results_seen++;
        end
    end

    // output stall: random stalls, long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = OUT_HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet_receiver && $urandom_range(0, 3) == 0) begin
                stall_left   = idle_length() - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // reset values, unused kind
    task automatic test_reset_state();
        send_item(mlcd_pkg::KIND_SCAN, 8'h00, 3'd7, 8'hFF);
        send_item(2'd3, 8'hFF, 3'd7, 8'hFF);
    endtask

    // every mode command, the register groups at their extremes, unknown page
    task automatic test_mode_commands();
        send_command(mlcd_pkg::CMD_DISPLAY | 8'h01);
        send_command(mlcd_pkg::CMD_SEG_DIR | 8'h01);
        send_command(mlcd_pkg::CMD_BIAS | 8'h01);
        send_command(mlcd_pkg::CMD_ALL_ON | 8'h01);
        send_command(mlcd_pkg::CMD_INVERSE | 8'h01);
        send_command(mlcd_pkg::CMD_COM_DIR | 8'h08);
        send_command(mlcd_pkg::CMD_RATIO | 8'h07);
        send_command(mlcd_pkg::CMD_POWER | 8'h07);
        send_command(mlcd_pkg::CMD_START_LINE | 8'h3F);
        send_command(mlcd_pkg::CMD_PAGE | 8'h07);
        send_command(mlcd_pkg::CMD_PAGE | 8'h08);
    endtask

    // operand bytes, data write while an operand is awaited
    task automatic test_operand_bytes();
        send_command(mlcd_pkg::CMD_VOLUME);
        send_data(8'hFF);
        send_command(8'hFF);
        send_command(mlcd_pkg::CMD_BOOSTER);
        send_command(8'hFF);
    endtask

    // write at the last column, write past it, read back
    task automatic test_column_end();
        send_command(mlcd_pkg::CMD_COL_HIGH | 8'h08);
        send_command(mlcd_pkg::CMD_COL_LOW | 8'h03);
        send_data(8'h00);
        send_data(8'hAA);
        send_item(mlcd_pkg::KIND_SCAN, 8'h00, 3'd7, 8'(COLUMNS - 1));
    endtask

    // register reset keeps ram, unknown command ignored
    task automatic test_register_reset();
        send_command(mlcd_pkg::CMD_RESET);
        send_command(8'h30);
    endtask

    // random traffic with one stretch of no idling on either side
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 6; chunk++) begin
            quiet_traffic  = (chunk == 3);
            quiet_receiver = (chunk == 3);
            run_random_traffic(240);
        end
        quiet_traffic  = 1'b0;
        quiet_receiver = 1'b0;
    endtask

    // long output hold-off while the sender keeps offering
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        run_random_traffic(80);
    endtask

    // sender pauses until every result has come, then resumes
    task automatic test_sender_pause();
        run_random_traffic(60);
        wait_for_drain();
        run_random_traffic(90);
    endtask

    // main sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= mlcd_pkg::KIND_CMD;
        i_bus_byte    <= 8'h00;
        i_scan_page   <= 3'd0;
        i_scan_column <= 8'd0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        quiet_traffic  = 1'b0;
        quiet_receiver = 1'b0;
        hold_request   = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_mode_commands();
        test_operand_bytes();
        test_column_end();
        test_register_reset();
        test_random_traffic();
        test_output_backpressure();
        test_sender_pause();

        wait_for_drain();
        repeat (END_SLACK_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
